>>> hdl/bhw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhw_pkg
// Shared types, codes and frame constants of the window group sequencer.
// ----------------------------------------------------------------------------
package bhw_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [7:0]  IDLE_CODE   = 8'h00;
    localparam logic [10:0] TX_ID       = 11'h750;

    localparam logic [7:0]  CMD_STOP    = 8'h00;
    localparam logic [7:0]  CMD_DOWN    = 8'h40;
    localparam logic [7:0]  CMD_UP      = 8'h80;

    localparam logic [7:0]  BUZ_SUB     = 8'h40;
    localparam logic [7:0]  HDR_BYTE1   = 8'h04;
    localparam logic [7:0]  HDR_BYTE2   = 8'h30;
    localparam logic [7:0]  BUZ_BYTE3   = 8'h14;
    localparam logic [7:0]  BUZ_BYTE4   = 8'h00;
    localparam logic [7:0]  BUZ_ON      = 8'h80;
    localparam logic [7:0]  BUZ_OFF     = 8'h00;
    localparam logic [7:0]  WIN_BYTE3   = 8'h01;
    localparam logic [7:0]  WIN_BYTE4   = 8'h01;
    localparam logic [7:0]  ACK_BYTE2   = 8'h70;
    localparam logic [7:0]  ACK_BYTE3   = 8'h01;
    localparam logic [3:0]  ACK_MIN_LEN = 4'd4;

    localparam logic [15:0] HORN_HOLD_RST    = 16'd200;
    localparam logic [15:0] MOVE_HOLD_RST    = 16'd150;
    localparam logic [15:0] MOVE_REFRESH_RST = 16'd750;
    localparam logic [15:0] ACK_TIMEOUT_RST  = 16'd60;
    localparam logic [3:0]  RETRY_LIMIT_RST  = 4'd2;
    localparam logic [7:0]  UP_CODE_RST      = 8'd1;
    localparam logic [7:0]  DOWN_CODE_RST    = 8'd2;
    localparam logic [7:0]  BACK_CODE_RST    = 8'd3;

    typedef enum logic [1:0] {
        OP_BUTTON = 2'd0,
        OP_TICK   = 2'd1,
        OP_FRAME  = 2'd2
    } opcode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_HORN_HOLD    = 3'd0,
        REG_MOVE_HOLD    = 3'd1,
        REG_MOVE_REFRESH = 3'd2,
        REG_ACK_TIMEOUT  = 3'd3,
        REG_RETRY_LIMIT  = 3'd4,
        REG_UP_CODE      = 3'd5,
        REG_DOWN_CODE    = 3'd6,
        REG_BACK_CODE    = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] horn_hold_ms;
        logic [15:0] move_hold_ms;
        logic [15:0] move_refresh_ms;
        logic [15:0] ack_timeout_ms;
        logic [3:0]  retry_limit;
        logic [7:0]  up_code;
        logic [7:0]  down_code;
        logic [7:0]  back_code;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] now_ms;
        logic [7:0]  button_code;
        logic [3:0]  frame_length;
        logic [7:0]  frame_byte0;
        logic [7:0]  frame_byte2;
        logic [7:0]  frame_byte3;
    } item_t;

    typedef struct packed {
        logic        frame_valid;
        logic [10:0] frame_id;
        logic [7:0]  data_byte0;
        logic [7:0]  data_byte1;
        logic [7:0]  data_byte2;
        logic [7:0]  data_byte3;
        logic [7:0]  data_byte4;
        logic [7:0]  data_byte5;
        logic [7:0]  data_byte6;
        logic [7:0]  data_byte7;
        logic        motion_busy;
        logic        last;
    } result_t;

    function automatic logic [7:0] sub_addr(input logic [1:0] idx);
        logic [7:0] addr;
        unique case (idx)
            2'd0: addr = 8'h90;
            2'd1: addr = 8'h91;
            2'd2: addr = 8'h93;
            2'd3: addr = 8'h92;
            default: addr = 8'h90;
        endcase
        return addr;
    endfunction

    function automatic result_t make_frame(input logic [7:0] b0, input logic [7:0] b3,
                                           input logic [7:0] b4, input logic [7:0] b5);
        result_t r;
        r.frame_valid = 1'b1;
        r.frame_id    = TX_ID;
        r.data_byte0  = b0;
        r.data_byte1  = HDR_BYTE1;
        r.data_byte2  = HDR_BYTE2;
        r.data_byte3  = b3;
        r.data_byte4  = b4;
        r.data_byte5  = b5;
        r.data_byte6  = 8'h00;
        r.data_byte7  = 8'h00;
        r.motion_busy = 1'b0;
        r.last        = 1'b0;
        return r;
    endfunction

endpackage

>>> hdl/bhw_item_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhw_item_if
// Input item channel: button change, tick or received frame.
// ----------------------------------------------------------------------------
interface bhw_item_if;
    import bhw_pkg::*;

    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] now_ms;
    logic [7:0]  button_code;
    logic [3:0]  frame_length;
    logic [7:0]  frame_byte0;
    logic [7:0]  frame_byte2;
    logic [7:0]  frame_byte3;

    modport source (
        output valid, opcode, now_ms, button_code, frame_length,
               frame_byte0, frame_byte2, frame_byte3,
        input  ready
    );

    modport sink (
        input  valid, opcode, now_ms, button_code, frame_length,
               frame_byte0, frame_byte2, frame_byte3,
        output ready
    );
endinterface

>>> hdl/bhw_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhw_result_if
// Result channel: one frame to send (or none) with busy and last flags.
// ----------------------------------------------------------------------------
interface bhw_result_if;
    import bhw_pkg::*;

    logic        valid;
    logic        ready;
    logic        frame_valid;
    logic [10:0] frame_id;
    logic [7:0]  data_byte0;
    logic [7:0]  data_byte1;
    logic [7:0]  data_byte2;
    logic [7:0]  data_byte3;
    logic [7:0]  data_byte4;
    logic [7:0]  data_byte5;
    logic [7:0]  data_byte6;
    logic [7:0]  data_byte7;
    logic        motion_busy;
    logic        last;

    modport source (
        output valid, frame_valid, frame_id, data_byte0, data_byte1, data_byte2,
               data_byte3, data_byte4, data_byte5, data_byte6, data_byte7,
               motion_busy, last,
        input  ready
    );

    modport sink (
        input  valid, frame_valid, frame_id, data_byte0, data_byte1, data_byte2,
               data_byte3, data_byte4, data_byte5, data_byte6, data_byte7,
               motion_busy, last,
        output ready
    );
endinterface

>>> hdl/bhw_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhw_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bhw_cfg_if;
    import bhw_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

>>> hdl/bhw_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhw_cfg_regs
// Configuration register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module bhw_cfg_regs (
    input  logic            clk,
    input  logic            rst_n,
    bhw_cfg_if.sink         cfg,
    output bhw_pkg::cfg_t   cfg_out
);
    import bhw_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid && cfg.ready;
    assign cfg_out   = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (cfg_index_t'(cfg.index))
                REG_HORN_HOLD:    cfg_next.horn_hold_ms    = cfg.data;
                REG_MOVE_HOLD:    cfg_next.move_hold_ms    = cfg.data;
                REG_MOVE_REFRESH: cfg_next.move_refresh_ms = cfg.data;
                REG_ACK_TIMEOUT:  cfg_next.ack_timeout_ms  = cfg.data;
                REG_RETRY_LIMIT:  cfg_next.retry_limit     = cfg.data[3:0];
                REG_UP_CODE:      cfg_next.up_code         = cfg.data[7:0];
                REG_DOWN_CODE:    cfg_next.down_code       = cfg.data[7:0];
                REG_BACK_CODE:    cfg_next.back_code       = cfg.data[7:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.horn_hold_ms    <= HORN_HOLD_RST;
            cfg_reg.move_hold_ms    <= MOVE_HOLD_RST;
            cfg_reg.move_refresh_ms <= MOVE_REFRESH_RST;
            cfg_reg.ack_timeout_ms  <= ACK_TIMEOUT_RST;
            cfg_reg.retry_limit     <= RETRY_LIMIT_RST;
            cfg_reg.up_code         <= UP_CODE_RST;
            cfg_reg.down_code       <= DOWN_CODE_RST;
            cfg_reg.back_code       <= BACK_CODE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end
endmodule

>>> hdl/bhw_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhw_engine
// Sequencer state and single-pass next-state logic for one registered item.
// ----------------------------------------------------------------------------
module bhw_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  bhw_pkg::item_t     item,
    input  bhw_pkg::cfg_t      cfg,
    output bhw_pkg::result_t   res0,
    output bhw_pkg::result_t   res1,
    output logic               res_two
);
    import bhw_pkg::*;

    typedef struct packed {
        logic [7:0]  held_code;
        logic [31:0] held_since;
        logic        horn_hold_on;
        logic [31:0] horn_hold_since;
        logic        buzzer_state;
        logic        move_active;
        logic [7:0]  move_command;
        logic [31:0] move_request_time;
        logic        group_running;
        logic [7:0]  group_command;
        logic [2:0]  target_index;
        logic        waiting_ack;
        logic [3:0]  retries_done;
        logic [31:0] sent_time;
        logic        pending_valid;
        logic [7:0]  pending_command;
    } eng_state_t;

    eng_state_t state_reg;
    eng_state_t state_next;

    always_comb
    begin
        eng_state_t s;
        logic [31:0] now;
        logic [31:0] horn_diff;
        logic [31:0] sent_diff;
        logic [31:0] held_diff;
        logic [31:0] req_diff;
        logic [7:0]  prev;
        logic        press;
        logic        rel;
        logic        do_stop;
        logic        do_queue;
        logic        do_advance;
        logic [7:0]  queue_cmd;
        logic [7:0]  move_cmd;
        logic        up;
        logic        down;
        logic        bz_emit;
        logic [7:0]  bz_val;
        logic        win_emit;
        logic [7:0]  win_sub;
        logic [7:0]  win_cmd;
        logic        busy;
        result_t     bz_frame;
        result_t     win_frame;
        result_t     idle_frame;

        s          = state_reg;
        now        = item.now_ms;
        horn_diff  = now - state_reg.horn_hold_since;
        sent_diff  = now - state_reg.sent_time;
        held_diff  = now - state_reg.held_since;
        req_diff   = now - state_reg.move_request_time;
        prev       = state_reg.held_code;
        press      = 1'b0;
        rel        = 1'b0;
        do_stop    = 1'b0;
        do_queue   = 1'b0;
        do_advance = 1'b0;
        queue_cmd  = CMD_STOP;
        move_cmd   = CMD_STOP;
        up         = 1'b0;
        down       = 1'b0;
        bz_emit    = 1'b0;
        bz_val     = BUZ_OFF;
        win_emit   = 1'b0;
        win_sub    = 8'h00;
        win_cmd    = CMD_STOP;

        if (item.opcode == OP_BUTTON)
        begin
            if (item.button_code != state_reg.held_code)
            begin
                s.held_code  = item.button_code;
                s.held_since = now;
                press = (prev == IDLE_CODE) && (item.button_code != IDLE_CODE);
                rel   = (prev != IDLE_CODE) && (item.button_code == IDLE_CODE);
                if (press && item.button_code == cfg.back_code)
                begin
                    s.horn_hold_on    = 1'b1;
                    s.horn_hold_since = now;
                end
                if (rel && prev == cfg.back_code)
                begin
                    s.horn_hold_on = 1'b0;
                    if (s.buzzer_state)
                    begin
                        s.buzzer_state = 1'b0;
                        bz_emit        = 1'b1;
                        bz_val         = BUZ_OFF;
                    end
                end
                if (rel && (prev == cfg.up_code || prev == cfg.down_code))
                begin
                    do_stop = 1'b1;
                end
            end
        end
        else if (item.opcode == OP_TICK)
        begin
            if (s.horn_hold_on && !s.buzzer_state && horn_diff >= {16'h0, cfg.horn_hold_ms})
            begin
                s.buzzer_state = 1'b1;
                bz_emit        = 1'b1;
                bz_val         = BUZ_ON;
            end
            if (!s.horn_hold_on && s.buzzer_state)
            begin
                s.buzzer_state = 1'b0;
                bz_emit        = 1'b1;
                bz_val         = BUZ_OFF;
            end

            // group send, resend or skip
            if (s.group_running)
            begin
                if (!s.waiting_ack)
                begin
                    win_emit      = 1'b1;
                    win_sub       = sub_addr(s.target_index[1:0]);
                    win_cmd       = s.group_command;
                    s.waiting_ack = 1'b1;
                    s.sent_time   = now;
                end
                else if (sent_diff >= {16'h0, cfg.ack_timeout_ms})
                begin
                    if (s.retries_done < cfg.retry_limit)
                    begin
                        s.retries_done = s.retries_done + 4'd1;
                        win_emit       = 1'b1;
                        win_sub        = sub_addr(s.target_index[1:0]);
                        win_cmd        = s.group_command;
                        s.sent_time    = now;
                    end
                    else
                    begin
                        do_advance = 1'b1;
                    end
                end
            end
        end
        else if (item.opcode == OP_FRAME)
        begin
            if (item.frame_length >= ACK_MIN_LEN && item.frame_byte2 == ACK_BYTE2
                && item.frame_byte3 == ACK_BYTE3 && s.group_running && s.waiting_ack
                && !s.target_index[2]
                && item.frame_byte0 == sub_addr(s.target_index[1:0]))
            begin
                do_advance = 1'b1;
            end
        end

        // advance to the next subaddress; after the last, close the group and start any pending one
        if (do_advance)
        begin
            s.retries_done = 4'd0;
            s.waiting_ack  = 1'b0;
            s.target_index = s.target_index + 3'd1;
            if (s.target_index[2])
            begin
                s.group_running = 1'b0;
                s.target_index  = 3'd0;
                if (s.pending_valid)
                begin
                    s.pending_valid = 1'b0;
                    s.group_command = s.pending_command;
                    s.target_index  = 3'd0;
                    s.waiting_ack   = 1'b0;
                    s.retries_done  = 4'd0;
                    s.sent_time     = now;
                    s.group_running = 1'b1;
                end
            end
        end

        // window hold and refresh
        if (item.opcode == OP_TICK)
        begin
            up   = (s.held_code == cfg.up_code);
            down = (s.held_code == cfg.down_code);
            if (!up && !down)
            begin
                do_stop = 1'b1;
            end
            else if (held_diff >= {16'h0, cfg.move_hold_ms})
            begin
                move_cmd = up ? CMD_UP : CMD_DOWN;
                if (!s.move_active || s.move_command != move_cmd)
                begin
                    s.move_active       = 1'b1;
                    s.move_command      = move_cmd;
                    s.move_request_time = now;
                    do_queue            = 1'b1;
                    queue_cmd           = move_cmd;
                end
                else if (req_diff >= {16'h0, cfg.move_refresh_ms})
                begin
                    s.move_request_time = now;
                    do_queue            = 1'b1;
                    queue_cmd           = move_cmd;
                end
            end
        end

        if (do_stop && s.move_active)
        begin
            s.move_active       = 1'b0;
            s.move_command      = CMD_STOP;
            s.move_request_time = 32'h0;
            s.pending_valid     = 1'b0;
            do_queue            = 1'b1;
            queue_cmd           = CMD_STOP;
        end

        if (do_queue)
        begin
            if (!s.group_running)
            begin
                s.group_command = queue_cmd;
                s.target_index  = 3'd0;
                s.waiting_ack   = 1'b0;
                s.retries_done  = 4'd0;
                s.sent_time     = now;
                s.group_running = 1'b1;
            end
            else
            begin
                s.pending_command = queue_cmd;
                s.pending_valid   = 1'b1;
            end
        end

        state_next = s;

        busy       = s.group_running || s.pending_valid || s.move_active;
        bz_frame   = make_frame(BUZ_SUB, BUZ_BYTE3, BUZ_BYTE4, bz_val);
        win_frame  = make_frame(win_sub, WIN_BYTE3, WIN_BYTE4, win_cmd);
        idle_frame = '0;

        res_two = bz_emit && win_emit;
        if (bz_emit)
        begin
            res0 = bz_frame;
        end
        else if (win_emit)
        begin
            res0 = win_frame;
        end
        else
        begin
            res0 = idle_frame;
        end
        res1 = win_frame;

        res0.motion_busy = busy;
        res0.last        = !res_two;
        res1.motion_busy = busy;
        res1.last        = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.held_code         <= IDLE_CODE;
            state_reg.held_since        <= 32'h0;
            state_reg.horn_hold_on      <= 1'b0;
            state_reg.horn_hold_since   <= 32'h0;
            state_reg.buzzer_state      <= 1'b0;
            state_reg.move_active       <= 1'b0;
            state_reg.move_command      <= CMD_STOP;
            state_reg.move_request_time <= 32'h0;
            state_reg.group_running     <= 1'b0;
            state_reg.group_command     <= CMD_STOP;
            state_reg.target_index      <= 3'd0;
            state_reg.waiting_ack       <= 1'b0;
            state_reg.retries_done      <= 4'd0;
            state_reg.sent_time         <= 32'h0;
            state_reg.pending_valid     <= 1'b0;
            state_reg.pending_command   <= CMD_STOP;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end
endmodule

>>> hdl/bhw_result_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhw_result_fifo
// Four-entry result queue: takes one or two results, returns one per transfer.
// ----------------------------------------------------------------------------
module bhw_result_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               push_two,
    input  bhw_pkg::result_t   push_d0,
    input  bhw_pkg::result_t   push_d1,
    output logic               room,
    output logic               head_valid,
    output bhw_pkg::result_t   head,
    input  logic               pop
);
    import bhw_pkg::*;

    result_t    entry_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_reg;
    logic [1:0] rd_ptr_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic [1:0] wr_ptr_inc;
    logic [2:0] push_n;

    assign room       = (count_reg <= 3'd2);
    assign head_valid = (count_reg != 3'd0);
    assign head       = entry_reg[rd_ptr_reg];
    assign wr_ptr_inc = wr_ptr_reg + 2'd1;

    always_comb
    begin
        push_n      = push ? (push_two ? 3'd2 : 3'd1) : 3'd0;
        wr_ptr_next = wr_ptr_reg + push_n[1:0];
        rd_ptr_next = pop ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
        count_next  = count_reg + push_n - {2'b00, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_d0;
            if (push_two)
            begin
                entry_reg[wr_ptr_inc] <= push_d1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule

>>> hdl/button_hold_window_group_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_hold_window_group_sequencer_core
// Buzzer and window-group sequencer driven by button, tick and frame items.
//
// Channels: item (sink) takes button changes, ticks and received frames;
// result (source) gives one or two results per item, the final one with
// last set; cfg (sink) writes the eight configuration registers, always
// ready; it must be written only while no item is in flight, which the block
// does not enforce. An accepted item is held in an input register and
// processed in one pass of logic into a four-entry result queue. A new item
// is taken every cycle while the queue has room for two results: with a ready
// receiver, items with one result flow at one per cycle, while ticks with
// two results are held back whenever that room is lacking; the result port
// gives one transfer per cycle while the receiver is ready. When the receiver
// stalls, results wait in the queue and the input register holds the next
// item; item.ready falls once that register is full and the queue lacks room
// for two. Reset clears the sequencer state, empties the queue and loads the
// configuration registers with their default values.
// ----------------------------------------------------------------------------
module button_hold_window_group_sequencer_core (
    input  logic        clk,
    input  logic        rst_n,
    bhw_item_if.sink    item,
    bhw_result_if.source result,
    bhw_cfg_if.sink     cfg
);
    import bhw_pkg::*;

    logic    in_valid_reg;
    logic    in_valid_next;
    item_t   in_item_reg;
    logic    item_xfer;
    logic    fire;
    logic    room;
    logic    head_valid;
    logic    res_two;
    result_t res0;
    result_t res1;
    result_t head;
    cfg_t    cfg_cur;

    assign fire       = in_valid_reg && room;
    assign item.ready = !in_valid_reg || fire;
    assign item_xfer  = item.valid && item.ready;

    always_comb
    begin
        if (item_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            in_item_reg.opcode       <= item.opcode;
            in_item_reg.now_ms       <= item.now_ms;
            in_item_reg.button_code  <= item.button_code;
            in_item_reg.frame_length <= item.frame_length;
            in_item_reg.frame_byte0  <= item.frame_byte0;
            in_item_reg.frame_byte2  <= item.frame_byte2;
            in_item_reg.frame_byte3  <= item.frame_byte3;
        end
    end

    bhw_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_cur)
    );

    bhw_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .item    (in_item_reg),
        .cfg     (cfg_cur),
        .res0    (res0),
        .res1    (res1),
        .res_two (res_two)
    );

    bhw_result_fifo u_result_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (fire),
        .push_two   (res_two),
        .push_d0    (res0),
        .push_d1    (res1),
        .room       (room),
        .head_valid (head_valid),
        .head       (head),
        .pop        (result.valid && result.ready)
    );

    assign result.valid       = head_valid;
    assign result.frame_valid = head.frame_valid;
    assign result.frame_id    = head.frame_id;
    assign result.data_byte0  = head.data_byte0;
    assign result.data_byte1  = head.data_byte1;
    assign result.data_byte2  = head.data_byte2;
    assign result.data_byte3  = head.data_byte3;
    assign result.data_byte4  = head.data_byte4;
    assign result.data_byte5  = head.data_byte5;
    assign result.data_byte6  = head.data_byte6;
    assign result.data_byte7  = head.data_byte7;
    assign result.motion_busy = head.motion_busy;
    assign result.last        = head.last;
endmodule

>>> tb/bhw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhw_checker
// Watches the item, result and register channels of the window group
// sequencer, predicts the frames and flags that each item transfer causes
// and compares every result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module bhw_checker (
    input  logic        clk,
    input  logic        rst_n,
    bhw_item_if         item,
    bhw_result_if       result,
    bhw_cfg_if          cfg,
    output int unsigned mismatches,
    output int unsigned outstanding
);
    import bhw_pkg::*;

    localparam logic [31:0] SUB_ORDER = {8'h92, 8'h93, 8'h91, 8'h90};

    cfg_t        knobs;
    logic [7:0]  held_code;
    logic [31:0] held_since;
    logic        horn_armed;
    logic [31:0] horn_since;
    logic        buzzer_on;
    logic        move_on;
    logic [7:0]  move_cmd;
    logic [31:0] move_time;
    logic        group_on;
    logic [7:0]  group_cmd;
    logic [2:0]  target;
    logic        awaiting_ack;
    logic [3:0]  retries;
    logic [31:0] sent_at;
    logic        queued_valid;
    logic [7:0]  queued_cmd;

    result_t     step_res [2];
    int          step_n;
    result_t     frames_due [$];
    int unsigned errors;

    function automatic void clear_state();
        knobs.horn_hold_ms    = HORN_HOLD_RST;
        knobs.move_hold_ms    = MOVE_HOLD_RST;
        knobs.move_refresh_ms = MOVE_REFRESH_RST;
        knobs.ack_timeout_ms  = ACK_TIMEOUT_RST;
        knobs.retry_limit     = RETRY_LIMIT_RST;
        knobs.up_code         = UP_CODE_RST;
        knobs.down_code       = DOWN_CODE_RST;
        knobs.back_code       = BACK_CODE_RST;
        held_code    = IDLE_CODE;
        held_since   = '0;
        horn_armed   = 1'b0;
        horn_since   = '0;
        buzzer_on    = 1'b0;
        move_on      = 1'b0;
        move_cmd     = CMD_STOP;
        move_time    = '0;
        group_on     = 1'b0;
        group_cmd    = CMD_STOP;
        target       = '0;
        awaiting_ack = 1'b0;
        retries      = '0;
        sent_at      = '0;
        queued_valid = 1'b0;
        queued_cmd   = CMD_STOP;
    endfunction

    function automatic void write_knob(input logic [CFG_INDEX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
        case (cfg_index_t'(idx))
            REG_HORN_HOLD:    knobs.horn_hold_ms    = data;
            REG_MOVE_HOLD:    knobs.move_hold_ms    = data;
            REG_MOVE_REFRESH: knobs.move_refresh_ms = data;
            REG_ACK_TIMEOUT:  knobs.ack_timeout_ms  = data;
            REG_RETRY_LIMIT:  knobs.retry_limit     = data[3:0];
            REG_UP_CODE:      knobs.up_code         = data[7:0];
            REG_DOWN_CODE:    knobs.down_code       = data[7:0];
            REG_BACK_CODE:    knobs.back_code       = data[7:0];
            default: ;
        endcase
    endfunction

    function automatic void push_frame(input logic [7:0] b0, input logic [7:0] b3,
                                       input logic [7:0] b4, input logic [7:0] b5);
        result_t r;
        if (step_n >= 2)
            return;
        r = '0;
        r.frame_valid = 1'b1;
        r.frame_id    = TX_ID;
        r.data_byte0  = b0;
        r.data_byte1  = HDR_BYTE1;
        r.data_byte2  = HDR_BYTE2;
        r.data_byte3  = b3;
        r.data_byte4  = b4;
        r.data_byte5  = b5;
        step_res[step_n] = r;
        step_n++;
    endfunction

    function automatic logic [7:0] current_sub();
        return SUB_ORDER[{target[1:0], 3'b000} +: 8];
    endfunction

    function automatic void drive_buzzer(input logic level);
        if (buzzer_on == level)
            return;
        buzzer_on = level;
        push_frame(BUZ_SUB, BUZ_BYTE3, BUZ_BYTE4, level ? BUZ_ON : BUZ_OFF);
    endfunction

    function automatic void start_group(input logic [7:0] cmd, input logic [31:0] now);
        group_cmd    = cmd;
        target       = '0;
        awaiting_ack = 1'b0;
        retries      = '0;
        sent_at      = now;
        group_on     = 1'b1;
    endfunction

    function automatic void queue_group(input logic [7:0] cmd, input logic [31:0] now);
        if (!group_on)
        begin
            start_group(cmd, now);
        end
        else
        begin
            queued_cmd   = cmd;
            queued_valid = 1'b1;
        end
    endfunction

    function automatic void advance_target(input logic [31:0] now);
        retries      = '0;
        awaiting_ack = 1'b0;
        target       = target + 3'd1;
        if (target >= 3'd4)
        begin
            group_on = 1'b0;
            target   = '0;
            if (queued_valid)
            begin
                queued_valid = 1'b0;
                start_group(queued_cmd, now);
            end
        end
    endfunction

    function automatic void stop_motion(input logic [31:0] now);
        if (!move_on)
            return;
        move_on      = 1'b0;
        move_cmd     = CMD_STOP;
        move_time    = '0;
        queued_valid = 1'b0;
        queue_group(CMD_STOP, now);
    endfunction

    function automatic void group_tick(input logic [31:0] now);
        logic [31:0] waited;
        if (!group_on)
            return;
        if (!awaiting_ack)
        begin
            push_frame(current_sub(), WIN_BYTE3, WIN_BYTE4, group_cmd);
            awaiting_ack = 1'b1;
            sent_at      = now;
            return;
        end
        waited = now - sent_at;
        if (waited < {16'h0000, knobs.ack_timeout_ms})
            return;
        if (retries < knobs.retry_limit)
        begin
            retries = retries + 4'd1;
            push_frame(current_sub(), WIN_BYTE3, WIN_BYTE4, group_cmd);
            sent_at = now;
            return;
        end
        advance_target(now);
    endfunction

    function automatic void window_tick(input logic [31:0] now);
        logic        up;
        logic        down;
        logic [7:0]  cmd;
        logic [31:0] held_for;
        logic [31:0] since_request;
        up   = (held_code == knobs.up_code);
        down = (held_code == knobs.down_code);
        if (!up && !down)
        begin
            stop_motion(now);
            return;
        end
        held_for = now - held_since;
        if (held_for < {16'h0000, knobs.move_hold_ms})
            return;
        cmd = up ? CMD_UP : CMD_DOWN;
        if (!move_on || move_cmd != cmd)
        begin
            move_on   = 1'b1;
            move_cmd  = cmd;
            move_time = now;
            queue_group(cmd, now);
            return;
        end
        since_request = now - move_time;
        if (since_request >= {16'h0000, knobs.move_refresh_ms})
        begin
            move_time = now;
            queue_group(cmd, now);
        end
    endfunction

    function automatic void take_button(input logic [7:0] code, input logic [31:0] now);
        logic [7:0] prev;
        logic       press;
        logic       release_now;
        prev = held_code;
        if (code == held_code)
            return;
        held_code   = code;
        held_since  = now;
        press       = (prev == IDLE_CODE) && (code != IDLE_CODE);
        release_now = (prev != IDLE_CODE) && (code == IDLE_CODE);
        if (press && code == knobs.back_code)
        begin
            horn_armed = 1'b1;
            horn_since = now;
        end
        if (release_now && prev == knobs.back_code)
        begin
            horn_armed = 1'b0;
            drive_buzzer(1'b0);
        end
        if (release_now && (prev == knobs.up_code || prev == knobs.down_code))
            stop_motion(now);
    endfunction

    function automatic void apply_item(input item_t it);
        logic [31:0] horn_age;
        logic        busy;
        step_n = 0;
        case (it.opcode)
            OP_BUTTON:
            begin
                take_button(it.button_code, it.now_ms);
            end
            OP_TICK:
            begin
                horn_age = it.now_ms - horn_since;
                if (horn_armed && !buzzer_on && horn_age >= {16'h0000, knobs.horn_hold_ms})
                    drive_buzzer(1'b1);
                if (!horn_armed && buzzer_on)
                    drive_buzzer(1'b0);
                group_tick(it.now_ms);
                window_tick(it.now_ms);
            end
            OP_FRAME:
            begin
                if (it.frame_length >= ACK_MIN_LEN && it.frame_byte2 == ACK_BYTE2 &&
                    it.frame_byte3 == ACK_BYTE3 && group_on && awaiting_ack &&
                    target < 3'd4 && it.frame_byte0 == current_sub())
                    advance_target(it.now_ms);
            end
            default: ;
        endcase
        if (step_n == 0)
        begin
            step_res[0] = '0;
            step_n = 1;
        end
        busy = group_on || queued_valid || move_on;
        for (int k = 0; k < step_n; k++)
        begin
            step_res[k].motion_busy = busy;
            step_res[k].last        = (k == step_n - 1);
            frames_due.push_back(step_res[k]);
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
            errors++;
        end
    endfunction

    function automatic void check_result();
        result_t want;
        if (frames_due.size() == 0)
        begin
            $error("result transfer with no result expected");
            errors++;
            return;
        end
        want = frames_due.pop_front();
        check_field("frame_valid", want.frame_valid, result.frame_valid);
        check_field("frame_id", want.frame_id, result.frame_id);
        check_field("data_byte0", want.data_byte0, result.data_byte0);
        check_field("data_byte1", want.data_byte1, result.data_byte1);
        check_field("data_byte2", want.data_byte2, result.data_byte2);
        check_field("data_byte3", want.data_byte3, result.data_byte3);
        check_field("data_byte4", want.data_byte4, result.data_byte4);
        check_field("data_byte5", want.data_byte5, result.data_byte5);
        check_field("data_byte6", want.data_byte6, result.data_byte6);
        check_field("data_byte7", want.data_byte7, result.data_byte7);
        check_field("motion_busy", want.motion_busy, result.motion_busy);
        check_field("last", want.last, result.last);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        item_t seen;
        if (!rst_n)
        begin
            clear_state();
            frames_due.delete();
            errors = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                write_knob(cfg.index, cfg.data);
            if (result.valid && result.ready)
                check_result();
            if (item.valid && item.ready)
            begin
                seen.opcode       = item.opcode;
                seen.now_ms       = item.now_ms;
                seen.button_code  = item.button_code;
                seen.frame_length = item.frame_length;
                seen.frame_byte0  = item.frame_byte0;
                seen.frame_byte2  = item.frame_byte2;
                seen.frame_byte3  = item.frame_byte3;
                apply_item(seen);
            end
        end
        outstanding <= frames_due.size();
        mismatches  <= errors;
    end

endmodule

>>> tb/tb_button_hold_window_group_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_hold_window_group_sequencer_core
// Drives button changes, ticks and acknowledgment frames into the sequencer
// under several register settings, with random gaps on the item side and
// random back-pressure on the result side, and reports the checker verdict.
// ----------------------------------------------------------------------------
module tb_button_hold_window_group_sequencer_core;
    import bhw_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    int unsigned mismatches;
    int unsigned outstanding;

    logic [31:0] clock_ms;
    logic [7:0]  last_sub = 8'h90;
    cfg_t        knobs;
    int unsigned items_sent;
    bit          steady;

    bhw_item_if   item ();
    bhw_result_if result ();
    bhw_cfg_if    cfg ();

    button_hold_window_group_sequencer_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cfg    (cfg)
    );

    bhw_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .result      (result),
        .cfg         (cfg),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    always @(posedge clk)
    begin
        if (result.valid && result.ready && result.frame_valid && result.data_byte0 != BUZ_SUB)
            last_sub <= result.data_byte0;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    initial
    begin : receiver
        int unsigned hold;
        int unsigned stall;
        int unsigned burst;
        int unsigned taken;
        bit [1:0]    pressed;
        result.ready = 1'b0;
        hold    = 0;
        stall   = 0;
        burst   = 0;
        taken   = 0;
        pressed = '0;
        forever
        begin
            @(posedge clk);
            if (result.valid && result.ready)
                taken++;
            if (hold == 0 && !pressed[0] && taken >= 400)
            begin
                pressed[0] = 1'b1;
                hold = 300;
            end
            if (hold == 0 && !pressed[1] && taken >= 1200)
            begin
                pressed[1] = 1'b1;
                hold = 300;
            end
            if (hold > 0)
            begin
                hold--;
                result.ready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                result.ready <= 1'b0;
            end
            else
            begin
                result.ready <= 1'b1;
                if (burst > 0)
                begin
                    burst--;
                end
                else
                begin
                    burst = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 150)
                                                        : $urandom_range(0, 6);
                    stall = pick_gap();
                end
            end
        end
    end

    function automatic item_t blank_item(input logic [1:0] op);
        item_t it;
        it.opcode       = op;
        it.now_ms       = clock_ms;
        it.button_code  = 8'($urandom);
        it.frame_length = 4'($urandom);
        it.frame_byte0  = 8'($urandom);
        it.frame_byte2  = 8'($urandom);
        it.frame_byte3  = 8'($urandom);
        return it;
    endfunction

    function automatic void wander();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            clock_ms += $urandom_range(0, 40);
        else if (r < 88)
            clock_ms += $urandom_range(40, 400);
        else if (r < 96)
            clock_ms += $urandom_range(400, 1500);
        else if (r < 98)
            clock_ms += $urandom_range(60000, 70000);
        else
            clock_ms = $urandom();
    endfunction

    task automatic send_item(input item_t it);
        int unsigned gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            item.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.valid        <= 1'b1;
        item.opcode       <= it.opcode;
        item.now_ms       <= it.now_ms;
        item.button_code  <= it.button_code;
        item.frame_length <= it.frame_length;
        item.frame_byte0  <= it.frame_byte0;
        item.frame_byte2  <= it.frame_byte2;
        item.frame_byte3  <= it.frame_byte3;
        do
            @(posedge clk);
        while (!item.ready);
        items_sent++;
        if (items_sent % 50 == 0)
            steady = ($urandom_range(0, 3) == 0);
    endtask

    task automatic press(input logic [7:0] code);
        item_t it;
        it = blank_item(OP_BUTTON);
        it.button_code = code;
        send_item(it);
    endtask

    task automatic tick();
        send_item(blank_item(OP_TICK));
    endtask

    task automatic ack(input logic [3:0] len, input logic [7:0] b0,
                       input logic [7:0] b2, input logic [7:0] b3);
        item_t it;
        it = blank_item(OP_FRAME);
        it.frame_length = len;
        it.frame_byte0  = b0;
        it.frame_byte2  = b2;
        it.frame_byte3  = b3;
        send_item(it);
    endtask

    task automatic reply();
        int unsigned r;
        logic [7:0]  sub;
        logic [3:0]  len;
        r = $urandom_range(0, 99);
        if (r < 70)
            sub = last_sub;
        else if (r < 90)
            sub = 8'h90 + 8'($urandom_range(0, 3));
        else
            sub = 8'($urandom);
        len = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(4, 15));
        ack(len, sub,
            ($urandom_range(0, 9) == 0) ? 8'($urandom) : ACK_BYTE2,
            ($urandom_range(0, 9) == 0) ? 8'($urandom) : ACK_BYTE3);
    endtask

    task automatic gesture();
        int unsigned r;
        logic [7:0]  code;
        r = $urandom_range(0, 99);
        if (r < 30)
            code = knobs.up_code;
        else if (r < 60)
            code = knobs.down_code;
        else if (r < 80)
            code = knobs.back_code;
        else if (r < 90)
            code = 8'($urandom);
        else
            code = IDLE_CODE;
        wander();
        press(code);
        repeat ($urandom_range(2, 12))
        begin
            wander();
            tick();
            if ($urandom_range(0, 1))
                reply();
            if ($urandom_range(0, 19) == 0)
            begin
                wander();
                press(($urandom_range(0, 1)) ? knobs.up_code : knobs.down_code);
            end
        end
        if ($urandom_range(0, 9) != 0)
        begin
            wander();
            press(IDLE_CODE);
        end
        repeat ($urandom_range(1, 6))
        begin
            wander();
            tick();
            if ($urandom_range(0, 1))
                reply();
        end
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do
            @(posedge clk);
        while (!cfg.ready);
    endtask

    task automatic drain();
        item.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic reconfigure(input logic [15:0] horn, input logic [15:0] move,
                               input logic [15:0] refresh, input logic [15:0] ack_wait,
                               input logic [15:0] retry, input logic [15:0] up,
                               input logic [15:0] down, input logic [15:0] back);
        drain();
        repeat (4) @(posedge clk);
        write_reg(REG_HORN_HOLD, horn);
        write_reg(REG_MOVE_HOLD, move);
        write_reg(REG_MOVE_REFRESH, refresh);
        write_reg(REG_ACK_TIMEOUT, ack_wait);
        write_reg(REG_RETRY_LIMIT, retry);
        write_reg(REG_UP_CODE, up);
        write_reg(REG_DOWN_CODE, down);
        write_reg(REG_BACK_CODE, back);
        cfg.valid <= 1'b0;
        knobs.horn_hold_ms    = horn;
        knobs.move_hold_ms    = move;
        knobs.move_refresh_ms = refresh;
        knobs.ack_timeout_ms  = ack_wait;
        knobs.retry_limit     = retry[3:0];
        knobs.up_code         = up[7:0];
        knobs.down_code       = down[7:0];
        knobs.back_code       = back[7:0];
    endtask

    task automatic directed();
        clock_ms = 32'd0;
        tick();
        send_item(blank_item(OP_UNUSED));
        ack(4'd3, 8'h90, ACK_BYTE2, ACK_BYTE3);
        clock_ms = 32'd1000;
        press(knobs.back_code);
        clock_ms = 32'd1100;
        tick();
        clock_ms = 32'd1200;
        tick();
        clock_ms = 32'd1250;
        press(IDLE_CODE);
        clock_ms = 32'd2000;
        press(knobs.up_code);
        clock_ms = 32'd2150;
        tick();
        clock_ms = 32'd2160;
        tick();
        // wrong subaddress first, then the one in flight
        ack(4'd8, 8'h91, ACK_BYTE2, ACK_BYTE3);
        ack(4'd15, 8'h90, ACK_BYTE2, ACK_BYTE3);
        clock_ms = 32'd2170;
        tick();
        clock_ms = 32'd2230;
        tick();
        clock_ms = 32'd2290;
        tick();
        clock_ms = 32'd2350;
        tick();
        clock_ms = 32'd2360;
        tick();
        clock_ms = 32'd2400;
        press(knobs.down_code);
        clock_ms = 32'd2560;
        tick();
        clock_ms = 32'd2600;
        press(IDLE_CODE);
        ack(4'd8, 8'h93, 8'h71, ACK_BYTE3);
        ack(4'd8, 8'h93, ACK_BYTE2, 8'h02);
        clock_ms = 32'hFFFF_FFA0;
        press(knobs.back_code);
        clock_ms = clock_ms + 32'h100;
        tick();
        press(IDLE_CODE);
    endtask

    initial
    begin : stimulus
        int unsigned budget;
        item.valid        = 1'b0;
        item.opcode       = OP_BUTTON;
        item.now_ms       = '0;
        item.button_code  = '0;
        item.frame_length = '0;
        item.frame_byte0  = '0;
        item.frame_byte2  = '0;
        item.frame_byte3  = '0;
        cfg.valid         = 1'b0;
        cfg.index         = REG_HORN_HOLD;
        cfg.data          = '0;
        rst_n             = 1'b0;
        clock_ms          = '0;
        items_sent        = 0;
        steady            = 1'b0;
        knobs.horn_hold_ms    = HORN_HOLD_RST;
        knobs.move_hold_ms    = MOVE_HOLD_RST;
        knobs.move_refresh_ms = MOVE_REFRESH_RST;
        knobs.ack_timeout_ms  = ACK_TIMEOUT_RST;
        knobs.retry_limit     = RETRY_LIMIT_RST;
        knobs.up_code         = UP_CODE_RST;
        knobs.down_code       = DOWN_CODE_RST;
        knobs.back_code       = BACK_CODE_RST;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        directed();

        for (int phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0: ;
                1: reconfigure('0, '0, '0, '0, '0, '0, '0, '0);
                2: reconfigure('1, '1, '1, '1, '1, '1, '1, '1);
                3: reconfigure(16'd40, 16'd30, 16'd120, 16'd25, 16'd3,
                               16'd5, 16'd5, 16'd6);
                default:
                    reconfigure(16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
                                16'($urandom_range(0, 900)), 16'($urandom_range(0, 120)),
                                {12'($urandom), 4'($urandom_range(0, 15))},
                                {8'($urandom), 8'($urandom_range(0, 5))},
                                {8'($urandom), 8'($urandom_range(0, 5))},
                                {8'($urandom), 8'($urandom_range(0, 5))});
            endcase
            budget = items_sent + 204;
            while (items_sent < budget)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    wander();
                    send_item(blank_item(2'($urandom_range(0, 3))));
                end
                else
                begin
                    gesture();
                end
            end
        end

        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
hdl/bhw_pkg.sv
hdl/bhw_item_if.sv
hdl/bhw_result_if.sv
hdl/bhw_cfg_if.sv
hdl/bhw_cfg_regs.sv
hdl/bhw_engine.sv
hdl/bhw_result_fifo.sv
hdl/button_hold_window_group_sequencer_core.sv
tb/bhw_checker.sv
tb/tb_button_hold_window_group_sequencer_core.sv
